// ----- sv/egcd_pkg.sv -----
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared widths, microcode encoding and program table for the GCD engine.
// ----------------------------------------------------------------------------
package egcd_pkg;

	localparam int WIDTH = 32;
	localparam int KW    = $clog2(WIDTH);

	typedef logic [WIDTH-1:0] word_t;
	typedef logic [KW-1:0]    shcnt_t;
	typedef logic [2:0]       upc_t;

	localparam upc_t UPC_IDLE   = 3'd0;
	localparam upc_t UPC_ORDER  = 3'd1;
	localparam upc_t UPC_TEST   = 3'd2;
	localparam upc_t UPC_ALIGN  = 3'd3;
	localparam upc_t UPC_REDUCE = 3'd4;
	localparam upc_t UPC_SWAP   = 3'd5;
	localparam upc_t UPC_DONE   = 3'd6;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_ORDER,
		OP_INIT,
		OP_ALIGN,
		OP_REDUCE,
		OP_SWAP
	} op_t;

	typedef enum logic [2:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_NO_START,
		CND_B_ZERO,
		CND_CAN_ALIGN,
		CND_K_NZ
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
		logic  done;
	} uword_t;

	typedef struct packed {
		op_t op;
	} ctrl_t;

	typedef struct packed {
		logic b_zero;
		logic can_align;
		logic k_nz;
	} status_t;

	function automatic uword_t ucode_rom(input upc_t addr);
		uword_t w;
		unique case (addr)
			UPC_IDLE:   w = '{OP_LOAD,   CND_NO_START,  UPC_IDLE,   1'b0};
			UPC_ORDER:  w = '{OP_ORDER,  CND_NEVER,     UPC_IDLE,   1'b0};
			UPC_TEST:   w = '{OP_INIT,   CND_B_ZERO,    UPC_DONE,   1'b0};
			UPC_ALIGN:  w = '{OP_ALIGN,  CND_CAN_ALIGN, UPC_ALIGN,  1'b0};
			UPC_REDUCE: w = '{OP_REDUCE, CND_K_NZ,      UPC_REDUCE, 1'b0};
			UPC_SWAP:   w = '{OP_SWAP,   CND_ALWAYS,    UPC_TEST,   1'b0};
			UPC_DONE:   w = '{OP_NOP,    CND_ALWAYS,    UPC_IDLE,   1'b1};
			default:    w = '{OP_NOP,    CND_ALWAYS,    UPC_IDLE,   1'b0};
		endcase
		return w;
	endfunction

endpackage

// ----- sv/egcd_sequencer.sv -----
// ----------------------------------------------------------------------------
// egcd_sequencer
// Step counter over the microcode table, with conditional jumps on status and start.
// ----------------------------------------------------------------------------
module egcd_sequencer import egcd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output ctrl_t   ctrl,
	output logic    busy,
	output logic    done
);

	upc_t   upc_q;
	upc_t   upc_next;
	uword_t uw;
	logic   take;

	assign uw = ucode_rom(upc_q);

	always_comb begin
		unique case (uw.cond)
			CND_NEVER:     take = 1'b0;
			CND_ALWAYS:    take = 1'b1;
			CND_NO_START:  take = !start;
			CND_B_ZERO:    take = status.b_zero;
			CND_CAN_ALIGN: take = status.can_align;
			CND_K_NZ:      take = status.k_nz;
			default:       take = 1'b1;
		endcase
		upc_next = take ? uw.target : upc_q + upc_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

	assign ctrl.op = uw.op;
	assign busy    = (upc_q != UPC_IDLE);
	assign done    = uw.done;

`ifndef SYNTHESIS
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("sequencer did not return to idle after result");
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not start the program");
	a_done_from_test: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(upc_q == UPC_TEST))
		else $error("result strobe not reached from the zero test");
`endif

endmodule

// ----- sv/egcd_datapath.sv -----
// ----------------------------------------------------------------------------
// egcd_datapath
// Operand registers with compare, subtract and one-bit shifts for remainders.
// ----------------------------------------------------------------------------
module egcd_datapath import egcd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  ctrl_t   ctrl,
	input  word_t   operand_a,
	input  word_t   operand_b,
	output status_t status,
	output word_t   divisor
);

	word_t  a_q;
	word_t  b_q;
	word_t  d_q;
	shcnt_t k_q;
	logic   a_lt_b;
	logic   a_ge_d;
	logic   can_align;

	assign a_lt_b    = (a_q < b_q);
	assign a_ge_d    = (a_q >= d_q);
	assign can_align = (d_q <= (a_q >> 1));

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				a_q <= operand_a;
				b_q <= operand_b;
			end
			OP_ORDER: begin
				if (a_lt_b) begin
					a_q <= b_q;
					b_q <= a_q;
				end
			end
			OP_INIT: begin
				d_q <= b_q;
				k_q <= '0;
			end
			OP_ALIGN: begin
				if (can_align) begin
					d_q <= d_q << 1;
					k_q <= k_q + shcnt_t'(1);
				end
			end
			OP_REDUCE: begin
				if (a_ge_d) begin
					a_q <= a_q - d_q;
				end
				if (k_q != '0) begin
					d_q <= d_q >> 1;
					k_q <= k_q - shcnt_t'(1);
				end
			end
			OP_SWAP: begin
				a_q <= b_q;
				b_q <= a_q;
			end
			default: begin
			end
		endcase
	end

	assign status.b_zero    = (b_q == '0);
	assign status.can_align = can_align;
	assign status.k_nz      = (k_q != '0);
	assign divisor          = a_q;

`ifndef SYNTHESIS
	a_swap_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_SWAP) |-> a_lt_b)
		else $error("remainder not below divisor at swap");
	a_reduce_final: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_REDUCE && k_q == '0) |=> a_lt_b)
		else $error("last reduce step left remainder too large");
	a_align_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_ALIGN) |-> (d_q != '0 && d_q <= a_q))
		else $error("shifted divisor out of range during align");
`endif

endmodule

// ----- sv/euclid_gcd_top.sv -----
// ----------------------------------------------------------------------------
// euclid_gcd_top
// Greatest common divisor of two unsigned words by Euclid's remainder method.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operand_a and operand_b and raise start; the transaction is taken on
//   a rising edge with start high and busy low. busy stays high until the
//   result is out. divisor is valid for exactly one cycle while done is high;
//   the receiver must take it then, since it cannot stall the block.
//   One transaction runs at a time. Each remainder step runs the zero test,
//   an align loop that shifts the divisor left while it fits, a reduce loop
//   that subtracts and shifts it back, and the swap; the shifts over all
//   steps add up to less than WIDTH. done falls on the cycle after the
//   strobe and a new start is taken then.
//   gcd(a,0) = a, gcd(0,b) = b and gcd(0,0) = 0.
//   Reset puts the step counter back to idle and drops any transaction in
//   flight; no result is produced for it.
// ----------------------------------------------------------------------------
module euclid_gcd_top import egcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  word_t operand_a,
	input  word_t operand_b,
	output logic  done,
	output word_t divisor
);

	ctrl_t   ctrl;
	status_t status;

	egcd_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	egcd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.status    (status),
		.divisor   (divisor)
	);

endmodule

// ----- test/euclid_gcd_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclid_gcd_top_tb
// Self-checking bench for the GCD engine: operand pairs are sent one
// transaction at a time and every divisor strobe is checked against a
// remainder-loop predictor. Edge operands come first, then random pairs
// with shared factors, Fibonacci worst cases, zeros and bit patterns.
// ----------------------------------------------------------------------------
module euclid_gcd_top_tb;
	import egcd_pkg::*;

	typedef struct {
		word_t a;
		word_t b;
	} operand_pair_t;

	localparam word_t ALL_ONES = '1;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  start     = 1'b0;
	word_t operand_a = '0;
	word_t operand_b = '0;
	logic  busy;
	logic  done;
	word_t divisor;

	logic          taken = 1'b0;
	operand_pair_t pending_pairs[$];
	word_t         gcd_expected[$];
	int            pairs_sent = 0;
	int            errors     = 0;

	euclid_gcd_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.done      (done),
		.divisor   (divisor)
	);

	function automatic word_t gcd_of(word_t x, word_t y);
		while (x != '0 && y != '0) begin
			if (x >= y)
				x = x % y;
			else
				y = y % x;
		end
		return x | y;
	endfunction

	function automatic operand_pair_t random_pair();
		operand_pair_t p;
		word_t         g;
		word_t         f0;
		word_t         f1;
		word_t         t;
		int            n;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				p.a = $urandom;
				p.b = $urandom;
			end
			3, 4: begin
				g   = $urandom_range(1, 65535);
				p.a = g * word_t'($urandom_range(0, 65535));
				p.b = g * word_t'($urandom_range(0, 65535));
			end
			5: begin
				f0 = '0;
				f1 = 1;
				n  = $urandom_range(2, 46);
				repeat (n) begin
					t  = f0 + f1;
					f0 = f1;
					f1 = t;
				end
				p.a = f1;
				p.b = f0;
			end
			6: begin
				p.a = $urandom >> $urandom_range(0, 31);
				p.b = '0;
			end
			7: begin
				p.a = $urandom_range(0, 255);
				p.b = $urandom_range(0, 255);
			end
			8: begin
				p.a = $urandom >> $urandom_range(0, 31);
				p.b = $urandom >> $urandom_range(0, 31);
			end
			default: begin
				p.a = $urandom >> $urandom_range(0, 31);
				p.b = p.a * word_t'($urandom_range(1, 15));
			end
		endcase
		if ($urandom_range(0, 1)) begin
			t   = p.a;
			p.a = p.b;
			p.b = t;
		end
		return p;
	endfunction

	task automatic queue_pair(input word_t a, input word_t b);
		operand_pair_t p;
		p.a = a;
		p.b = b;
		pending_pairs.push_back(p);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// hold start until the transaction is taken, then advance or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || taken) begin
			if (pending_pairs.size() != 0 &&
			    ((pairs_sent >= 400 && pairs_sent < 650) || $urandom_range(0, 99) >= 27)) begin
				start     <= 1'b1;
				operand_a <= pending_pairs[0].a;
				operand_b <= pending_pairs[0].b;
				pending_pairs.pop_front();
				pairs_sent++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		word_t want;
		if (arst_n) begin
			if (done) begin
				if (gcd_expected.size() == 0) begin
					$display("%0t: divisor with none pending: expected none, actual %0h",
					         $time, divisor);
					errors++;
				end else begin
					want = gcd_expected.pop_front();
					if (divisor !== want) begin
						$display("%0t: divisor mismatch: expected %0h, actual %0h",
						         $time, want, divisor);
						errors++;
					end
				end
			end
			if (start && !busy)
				gcd_expected.push_back(gcd_of(operand_a, operand_b));
			taken <= start && !busy;
		end else begin
			taken <= 1'b0;
		end
	end

	initial begin
		queue_pair('0, '0);
		queue_pair('0, ALL_ONES);
		queue_pair(ALL_ONES, '0);
		queue_pair('0, 1);
		queue_pair(1, '0);
		queue_pair(ALL_ONES, ALL_ONES);
		queue_pair(1, ALL_ONES);
		queue_pair(ALL_ONES, 1);
		queue_pair(ALL_ONES - 1, ALL_ONES);
		queue_pair(32'd2971215073, 32'd1836311903);
		queue_pair(32'd1836311903, 32'd2971215073);
		queue_pair(32'h8000_0000, 32'h4000_0000);
		queue_pair(32'h8000_0000, 32'h0000_0001);
		queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
		queue_pair(32'd4294967291, 32'd4294967279);
		queue_pair(32'd12345 * 32'd3001, 32'd12345 * 32'd2999);
		queue_pair(32'hDEAD_BEEF, 32'hDEAD_BEEF);
		queue_pair(32'd6, 32'd4);
		queue_pair(32'd7, 32'd49);
		for (int i = 0; i < 1250; i++)
			pending_pairs.push_back(random_pair());

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_pairs.size() != 0 || start || gcd_expected.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);

		if (errors == 0 && gcd_expected.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("%0t: timeout with %0d divisors pending", $time, gcd_expected.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- files.f -----
sv/egcd_pkg.sv
sv/egcd_sequencer.sv
sv/egcd_datapath.sv
sv/euclid_gcd_top.sv
test/euclid_gcd_top_tb.sv
